// ----- hw/rtl/c6502_pkg.sv -----
// c6502_pkg: opcodes, flag positions and shared types for the 6502 execute unit
// no dependencies
package c6502_pkg;

	localparam logic [7:0] OP_PHP = 8'h08, OP_PHA = 8'h48, OP_PLP = 8'h28, OP_PLA = 8'h68;
	localparam logic [7:0] OP_ORA = 8'h09, OP_AND = 8'h29, OP_EOR = 8'h49, OP_ADC = 8'h69;
	localparam logic [7:0] OP_SBC = 8'hE9, OP_CMP = 8'hC9, OP_CPY = 8'hC0, OP_CPX = 8'hE0;
	localparam logic [7:0] OP_ASL = 8'h0A, OP_LSR = 8'h4A, OP_ROL = 8'h2A, OP_ROR = 8'h6A;
	localparam logic [7:0] OP_BITZ = 8'h24, OP_BITA = 8'h2C;
	localparam logic [7:0] OP_CLC = 8'h18, OP_SEC = 8'h38, OP_SEI = 8'h78, OP_CLD = 8'hD8;
	localparam logic [7:0] OP_SED = 8'hF8, OP_CLV = 8'hB8;
	localparam logic [7:0] OP_BPL = 8'h10, OP_BMI = 8'h30, OP_BVC = 8'h50, OP_BVS = 8'h70;
	localparam logic [7:0] OP_BCC = 8'h90, OP_BCS = 8'hB0, OP_BNE = 8'hD0, OP_BEQ = 8'hF0;
	localparam logic [7:0] OP_JMP = 8'h4C, OP_JSR = 8'h20, OP_RTS = 8'h60, OP_RTI = 8'h40;
	localparam logic [7:0] OP_STYZ = 8'h84, OP_STAZ = 8'h85, OP_STXZ = 8'h86, OP_STXA = 8'h8E;
	localparam logic [7:0] OP_DEY = 8'h88, OP_INY = 8'hC8, OP_DEX = 8'hCA, OP_INX = 8'hE8;
	localparam logic [7:0] OP_TXA = 8'h8A, OP_TYA = 8'h98, OP_TAX = 8'hAA, OP_TAY = 8'hA8;
	localparam logic [7:0] OP_TXS = 8'h9A, OP_TSX = 8'hBA;
	localparam logic [7:0] OP_LDYI = 8'hA0, OP_LDXI = 8'hA2, OP_LDAI = 8'hA9;
	localparam logic [7:0] OP_LDYA = 8'hAC, OP_LDAA = 8'hAD, OP_LDXA = 8'hAE, OP_NOP = 8'hEA;

	localparam int FL_C = 0, FL_Z = 1, FL_I = 2, FL_D = 3, FL_B = 4, FL_U = 5, FL_V = 6, FL_N = 7;

	localparam logic [7:0]  SP_RESET = 8'hFD;
	localparam logic [7:0]  P_RESET  = 8'h24;
	localparam logic [7:0]  STACK_PAGE = 8'h01;

	typedef struct packed {
		logic [7:0]  a;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [7:0]  sp;
		logic [7:0]  p;
		logic [15:0] pc;
	} regs_t;

	typedef struct packed {
		logic        wv;
		logic [15:0] wa;
		logic [7:0]  wd;
		logic        wv2;
		logic [15:0] wa2;
		logic [7:0]  wd2;
		logic [2:0]  cyc;
		logic        unk;
		logic        two;
	} res_t;

	typedef struct packed {
		logic [7:0] cmd;
		logic [7:0] lo;
		logic [7:0] hi;
		logic [7:0] md;
		logic [7:0] s1;
		logic [7:0] s2;
		logic [7:0] s3;
	} item_t;

endpackage

// ----- hw/rtl/cpu6502_instruction_execute.sv -----
// cpu6502_instruction_execute: top level of the 6502 subset execute unit
// depends on c6502_pkg, c6502_alu, c6502_regs
//
// channel   direction  handshake          payload
// in        sink       in_valid/in_stall  cmd operands mem_data stack bytes
// out       source     out_valid/out_stall write_*, register snapshot, flags
// cfg       sink       cfg_valid/cfg_ready start_address
//
// an item goes into an input register; combinational decode/execute logic updates the
// architectural registers and fills the result register, which drives the outputs
// JSR holds its second push in the result register, so it gives two output results;
// other instructions sustain one item per cycle while out_stall is low
// reset sets A X Y 0, SP 0xFD, P 0x24, PC 0; a cfg write loads PC with the start address
// output stall back-pressures into the input register and then to in_stall
module cpu6502_instruction_execute (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  cmd,
	input  logic [7:0]  operand_lo,
	input  logic [7:0]  operand_hi,
	input  logic [7:0]  mem_data,
	input  logic [7:0]  stack_byte_one,
	input  logic [7:0]  stack_byte_two,
	input  logic [7:0]  stack_byte_three,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        write_valid,
	output logic [15:0] write_address,
	output logic [7:0]  write_data,
	output logic [7:0]  acc_out,
	output logic [7:0]  x_out,
	output logic [7:0]  y_out,
	output logic [7:0]  sp_out,
	output logic [7:0]  status_out,
	output logic [15:0] pc_out,
	output logic [2:0]  cycle_count,
	output logic        unknown_op,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);
	import c6502_pkg::*;

	item_t it_s1;
	logic  v_s1;
	regs_t cur, nxt, snap_s2;
	res_t  res, res_s2;
	logic  v_s2, second_s2;
	logic  out_take, s2_free, adv;

	// output stage frees when empty or when its final result leaves
	assign out_take = v_s2 & ~out_stall;
	assign s2_free  = ~v_s2 | (out_take & (~res_s2.two | second_s2));
	assign adv      = v_s1 & s2_free;
	assign in_stall = v_s1 & ~s2_free;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (~in_stall) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid & ~in_stall) begin
			it_s1 <= '{cmd: cmd, lo: operand_lo, hi: operand_hi, md: mem_data,
				s1: stack_byte_one, s2: stack_byte_two, s3: stack_byte_three};
		end
	end

	c6502_alu u_alu (.it(it_s1), .cur(cur), .nxt(nxt), .res(res));

	c6502_regs u_regs (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_valid & cfg_ready),
		.cfg_data(cfg_data), .upd(adv), .nxt(nxt), .cur(cur)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2      <= 1'b0;
			second_s2 <= 1'b0;
		end else if (adv) begin
			v_s2      <= 1'b1;
			second_s2 <= 1'b0;
		end else if (out_take) begin
			// JSR steps to its second push, else the stage empties
			if (res_s2.two & ~second_s2) begin
				second_s2 <= 1'b1;
			end else begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2  <= res;
			snap_s2 <= nxt;
		end
	end

	assign out_valid     = v_s2;
	assign write_valid   = second_s2 ? res_s2.wv2 : res_s2.wv;
	assign write_address = second_s2 ? res_s2.wa2 : res_s2.wa;
	assign write_data    = second_s2 ? res_s2.wd2 : res_s2.wd;
	assign acc_out       = snap_s2.a;
	assign x_out         = snap_s2.x;
	assign y_out         = snap_s2.y;
	assign sp_out        = snap_s2.sp;
	assign status_out    = (snap_s2.p & 8'hEF) | 8'h20;
	assign pc_out        = snap_s2.pc;
	assign cycle_count   = res_s2.cyc;
	assign unknown_op    = res_s2.unk;
	assign last          = ~res_s2.two | second_s2;
endmodule

// ----- hw/rtl/c6502_alu.sv -----
// c6502_alu: combinational next-state logic for one instruction
// depends on c6502_pkg
module c6502_alu (
	input  c6502_pkg::item_t it,
	input  c6502_pkg::regs_t cur,
	output c6502_pkg::regs_t nxt,
	output c6502_pkg::res_t  res
);
	import c6502_pkg::*;

	logic [8:0]  sum;
	logic [7:0]  addv, t, cmpr;
	logic [15:0] pc1, pc2, pc3, absa, btgt;
	logic        docmp, nz, taken, isbr;

	always_comb begin
		nxt   = cur;
		res   = '0;
		res.cyc = 3'd2;
		absa  = {it.hi, it.lo};
		pc1   = cur.pc + 16'd1;
		pc2   = cur.pc + 16'd2;
		pc3   = cur.pc + 16'd3;
		btgt  = pc2 + {{8{it.lo[7]}}, it.lo};
		addv  = (it.cmd == OP_SBC) ? ~it.lo : it.lo;
		sum   = {1'b0, cur.a} + {1'b0, addv} + {8'd0, cur.p[FL_C]};
		t     = '0;
		cmpr  = cur.a;
		docmp = 1'b0;
		nz    = 1'b0;
		taken = 1'b0;
		isbr  = 1'b0;
		nxt.pc = pc1;
		unique case (it.cmd)
			OP_PHP: begin
				res.wv = 1'b1; res.wa = {STACK_PAGE, cur.sp};
				res.wd = cur.p | 8'h30; nxt.sp = cur.sp - 8'd1; res.cyc = 3'd3;
			end
			OP_PHA: begin
				res.wv = 1'b1; res.wa = {STACK_PAGE, cur.sp};
				res.wd = cur.a; nxt.sp = cur.sp - 8'd1; res.cyc = 3'd3;
			end
			OP_PLP: begin
				nxt.sp = cur.sp + 8'd1; nxt.p = (it.s1 & 8'hCF) | 8'h20; res.cyc = 3'd4;
			end
			OP_PLA: begin
				nxt.sp = cur.sp + 8'd1; nxt.a = it.s1; t = it.s1; nz = 1'b1; res.cyc = 3'd4;
			end
			OP_ORA: begin nxt.a = cur.a | it.lo; t = nxt.a; nz = 1'b1; nxt.pc = pc2; end
			OP_AND: begin nxt.a = cur.a & it.lo; t = nxt.a; nz = 1'b1; nxt.pc = pc2; end
			OP_EOR: begin nxt.a = cur.a ^ it.lo; t = nxt.a; nz = 1'b1; nxt.pc = pc2; end
			OP_ADC, OP_SBC: begin
				nxt.a = sum[7:0]; t = sum[7:0]; nz = 1'b1; nxt.pc = pc2;
				nxt.p[FL_C] = sum[8];
				nxt.p[FL_V] = ~(cur.a[7] ^ addv[7]) & (cur.a[7] ^ sum[7]);
			end
			OP_CMP: begin cmpr = cur.a; docmp = 1'b1; nxt.pc = pc2; end
			OP_CPY: begin cmpr = cur.y; docmp = 1'b1; nxt.pc = pc2; end
			OP_CPX: begin cmpr = cur.x; docmp = 1'b1; nxt.pc = pc2; end
			OP_ASL: begin
				nxt.p[FL_C] = cur.a[7]; nxt.a = {cur.a[6:0], 1'b0}; t = nxt.a; nz = 1'b1;
			end
			OP_LSR: begin
				nxt.p[FL_C] = cur.a[0]; nxt.a = {1'b0, cur.a[7:1]}; t = nxt.a; nz = 1'b1;
			end
			OP_ROL: begin
				nxt.p[FL_C] = cur.a[7]; nxt.a = {cur.a[6:0], cur.p[FL_C]}; t = nxt.a; nz = 1'b1;
			end
			OP_ROR: begin
				nxt.p[FL_C] = cur.a[0]; nxt.a = {cur.p[FL_C], cur.a[7:1]}; t = nxt.a; nz = 1'b1;
			end
			OP_BITZ, OP_BITA: begin
				nxt.p[FL_N] = it.md[7]; nxt.p[FL_V] = it.md[6];
				nxt.p[FL_Z] = ((cur.a & it.md) == 8'd0); res.cyc = 3'd4;
				nxt.pc = (it.cmd == OP_BITZ) ? pc2 : pc3;
			end
			OP_CLC: nxt.p[FL_C] = 1'b0;
			OP_SEC: nxt.p[FL_C] = 1'b1;
			OP_SEI: nxt.p[FL_I] = 1'b1;
			OP_CLD: nxt.p[FL_D] = 1'b0;
			OP_SED: nxt.p[FL_D] = 1'b1;
			OP_CLV: nxt.p[FL_V] = 1'b0;
			OP_BPL: begin isbr = 1'b1; taken = ~cur.p[FL_N]; end
			OP_BMI: begin isbr = 1'b1; taken =  cur.p[FL_N]; end
			OP_BVC: begin isbr = 1'b1; taken = ~cur.p[FL_V]; end
			OP_BVS: begin isbr = 1'b1; taken =  cur.p[FL_V]; end
			OP_BCC: begin isbr = 1'b1; taken = ~cur.p[FL_C]; end
			OP_BCS: begin isbr = 1'b1; taken =  cur.p[FL_C]; end
			OP_BNE: begin isbr = 1'b1; taken = ~cur.p[FL_Z]; end
			OP_BEQ: begin isbr = 1'b1; taken =  cur.p[FL_Z]; end
			OP_JMP: begin nxt.pc = absa; res.cyc = 3'd3; end
			OP_JSR: begin
				res.two = 1'b1; res.cyc = 3'd6;
				res.wv = 1'b1;  res.wa = {STACK_PAGE, cur.sp}; res.wd = pc2[15:8];
				res.wv2 = 1'b1; res.wa2 = {STACK_PAGE, cur.sp - 8'd1}; res.wd2 = pc2[7:0];
				nxt.sp = cur.sp - 8'd2; nxt.pc = absa;
			end
			OP_RTS: begin
				nxt.sp = cur.sp + 8'd2; nxt.pc = {it.s2, it.s1} + 16'd1; res.cyc = 3'd6;
			end
			OP_RTI: begin
				nxt.sp = cur.sp + 8'd3; nxt.p = (it.s1 & 8'hCF) | 8'h20;
				nxt.pc = {it.s3, it.s2}; res.cyc = 3'd6;
			end
			OP_STYZ: begin
				res.wv = 1'b1; res.wa = {8'd0, it.lo}; res.wd = cur.y; res.cyc = 3'd3; nxt.pc = pc2;
			end
			OP_STAZ: begin
				res.wv = 1'b1; res.wa = {8'd0, it.lo}; res.wd = cur.a; res.cyc = 3'd3; nxt.pc = pc2;
			end
			OP_STXZ: begin
				res.wv = 1'b1; res.wa = {8'd0, it.lo}; res.wd = cur.x; res.cyc = 3'd3; nxt.pc = pc2;
			end
			OP_STXA: begin
				res.wv = 1'b1; res.wa = absa; res.wd = cur.x; res.cyc = 3'd4; nxt.pc = pc3;
			end
			OP_DEY: begin nxt.y = cur.y - 8'd1; t = nxt.y; nz = 1'b1; end
			OP_INY: begin nxt.y = cur.y + 8'd1; t = nxt.y; nz = 1'b1; end
			OP_DEX: begin nxt.x = cur.x - 8'd1; t = nxt.x; nz = 1'b1; end
			OP_INX: begin nxt.x = cur.x + 8'd1; t = nxt.x; nz = 1'b1; end
			OP_TXA: begin nxt.a = cur.x; t = cur.x; nz = 1'b1; end
			OP_TYA: begin nxt.a = cur.y; t = cur.y; nz = 1'b1; end
			OP_TAX: begin nxt.x = cur.a; t = cur.a; nz = 1'b1; end
			OP_TAY: begin nxt.y = cur.a; t = cur.a; nz = 1'b1; end
			OP_TXS: nxt.sp = cur.x;
			OP_TSX: begin nxt.x = cur.sp; t = cur.sp; nz = 1'b1; end
			OP_LDYI: begin nxt.y = it.lo; t = it.lo; nz = 1'b1; nxt.pc = pc2; end
			OP_LDXI: begin nxt.x = it.lo; t = it.lo; nz = 1'b1; nxt.pc = pc2; end
			OP_LDAI: begin nxt.a = it.lo; t = it.lo; nz = 1'b1; nxt.pc = pc2; end
			OP_LDYA: begin nxt.y = it.md; t = it.md; nz = 1'b1; res.cyc = 3'd4; nxt.pc = pc3; end
			OP_LDAA: begin nxt.a = it.md; t = it.md; nz = 1'b1; res.cyc = 3'd4; nxt.pc = pc3; end
			OP_LDXA: begin nxt.x = it.md; t = it.md; nz = 1'b1; res.cyc = 3'd4; nxt.pc = pc3; end
			OP_NOP: ;
			default: res.unk = 1'b1;
		endcase
		if (docmp) begin
			t = cmpr - it.lo; nz = 1'b1; nxt.p[FL_C] = (cmpr >= it.lo);
		end
		if (isbr) begin
			nxt.pc = taken ? btgt : pc2;
			res.cyc = taken ? 3'd3 : 3'd2;
		end
		if (nz) begin
			nxt.p[FL_Z] = (t == 8'd0);
			nxt.p[FL_N] = t[7];
		end
	end
endmodule

// ----- hw/rtl/c6502_regs.sv -----
// c6502_regs: architectural register file with reset and start address latch
// depends on c6502_pkg
module c6502_regs (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [15:0]      cfg_data,
	input  logic             upd,
	input  c6502_pkg::regs_t nxt,
	output c6502_pkg::regs_t cur
);
	import c6502_pkg::*;

	regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '{a: 8'd0, x: 8'd0, y: 8'd0, sp: SP_RESET, p: P_RESET, pc: 16'd0};
		end else if (cfg_we) begin
			regs_q.pc <= cfg_data;
		end else if (upd) begin
			regs_q <= nxt;
		end
	end

	assign cur = regs_q;
endmodule

// ----- hw/rtl/c6502_checker.sv -----
// c6502_checker: port-level checks on the execute unit, bound to the top level
// depends on cpu6502_instruction_execute ports only
module c6502_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        write_valid,
	input logic [15:0] write_address,
	input logic [7:0]  status_out,
	input logic [2:0]  cycle_count,
	input logic        unknown_op,
	input logic        last
);
	a_status_bits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status_out[5] && !status_out[4])) else $error("status bits 4/5 wrong");
	a_cycles: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cycle_count >= 3'd2 && cycle_count <= 3'd6)) else $error("cycle count range");
	a_jsr_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last) |=> (out_valid && last && write_valid))
		else $error("jsr second push missing");
	a_unk: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && unknown_op) |-> (!write_valid && last && cycle_count == 3'd2))
		else $error("unknown op result wrong");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(write_address)))
		else $error("stalled result changed");
endmodule

bind cpu6502_instruction_execute c6502_checker u_chk (.*);
